>>> rtl/core/utf8sd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_pkg
// shared types and constants for the streaming utf-8 decoder
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;

    // continuation bytes still expected after a lead byte
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_ONE   = 2'd1;
    localparam logic [1:0] PEND_TWO   = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } t_in_word;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            malformed;
        logic            string_done;
    } t_out_word;

    typedef struct packed {
        logic [1:0]      pending;
        logic [CP_W-1:0] partial;
        logic            bad;
    } t_dec_state;

endpackage

>>> rtl/core/utf8sd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_decode
// one-byte step of the decoder: next sequence state and the optional result
// ----------------------------------------------------------------------------
module utf8sd_decode (
    input  utf8sd_pkg::t_dec_state            i_state,
    input  utf8sd_pkg::t_in_word              i_word,
    input  logic [utf8sd_pkg::CP_W-1:0]       i_repl_code,
    output utf8sd_pkg::t_dec_state            o_state,
    output logic                              o_res_valid,
    output utf8sd_pkg::t_out_word             o_res
);
    import utf8sd_pkg::*;

    logic [7:0]      b;
    logic            eos;
    logic [CP_W-1:0] shifted;
    logic [1:0]      pend_dec;
    logic            cont_bad;

    assign b        = i_word.data_byte;
    assign eos      = i_word.end_of_string;
    assign shifted  = {i_state.partial[CP_W-7:0], b[5:0]};
    assign pend_dec = i_state.pending - 2'd1;
    assign cont_bad = i_state.bad | (b[7:6] != 2'b10);

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '{code_point: i_repl_code, malformed: 1'b1, string_done: eos};

        if (i_state.pending == PEND_NONE) begin
            if (b inside {[8'h00:8'h7F]}) begin
                o_res_valid = 1'b1;
                o_res       = '{code_point: {13'd0, b}, malformed: 1'b0, string_done: eos};
            end else if (b inside {[8'hC0:8'hF7]}) begin
                if (eos) begin
                    // lead byte is the last of the string
                    o_res_valid = 1'b1;
                    o_state     = '0;
                end else begin
                    o_state.bad = 1'b0;
                    if (b inside {[8'hC0:8'hDF]}) begin
                        o_state.pending = PEND_ONE;
                        o_state.partial = {16'd0, b[4:0]};
                    end else if (b inside {[8'hE0:8'hEF]}) begin
                        o_state.pending = PEND_TWO;
                        o_state.partial = {17'd0, b[3:0]};
                    end else begin
                        o_state.pending = PEND_THREE;
                        o_state.partial = {18'd0, b[2:0]};
                    end
                end
            end else begin
                // stray continuation byte or 11111xxx
                o_res_valid = 1'b1;
            end
        end else begin
            if (pend_dec == PEND_NONE) begin
                o_res_valid = 1'b1;
                o_res       = '{code_point: cont_bad ? i_repl_code : shifted,
                                malformed: cont_bad, string_done: eos};
                o_state     = '0;
            end else if (eos) begin
                // sequence cut short by end of string
                o_res_valid = 1'b1;
                o_state     = '0;
            end else begin
                o_state = '{pending: pend_dec, partial: shifted, bad: cont_bad};
            end
        end
    end

endmodule

>>> rtl/core/utf8_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// streaming utf-8 decoder: bytes in, code points out
// ----------------------------------------------------------------------------
// Takes one byte per word, with an end-of-string flag, and returns one code
// point word for each completed sequence, each invalid lead byte and each
// sequence cut short by the end of the string. The block sustains one byte
// per clock cycle while the output is not stalled: the only loop is the
// per-byte sequence state (pending count, gathered bits, bad flag), which is
// updated by a few compares and a six-bit shift. An accepted byte is held in
// the input register and decoded from there into the result register once
// the result register is free. Bytes that only extend a sequence yield no
// result word. The replacement code register resets to U+FFFD and should be
// written only while the block is idle; overlong forms, surrogates and
// values above U+10FFFF pass unchanged.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  utf8sd_pkg::t_in_word         i_in_word,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output utf8sd_pkg::t_out_word        o_out_word,
    input  logic                         i_cfg_wr_en,
    input  logic [utf8sd_pkg::CP_W-1:0]  i_cfg_wr_data
);
    import utf8sd_pkg::*;

    // input register
    logic       r_in_valid;
    t_in_word   r_in_word;
    // sequence state
    t_dec_state r_state;
    t_dec_state n_state;
    // result register
    logic       r_out_valid;
    t_out_word  r_out_word;
    // configuration
    logic [CP_W-1:0] r_repl_code;

    logic       out_free;
    logic       dec_fire;
    logic       in_fire;
    logic       res_valid;
    t_out_word  res_word;

    // result slot is free when empty or being taken this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    // the held byte is decoded only when its result has somewhere to go
    assign dec_fire   = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_fire    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    utf8sd_decode u_decode (
        .i_state     (r_state),
        .i_word      (r_in_word),
        .i_repl_code (r_repl_code),
        .o_state     (n_state),
        .o_res_valid (res_valid),
        .o_res       (res_word)
    );

    // input register: refills in the same cycle the held byte moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_word <= i_in_word;
        end
    end

    // sequence state advances once per decoded byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (dec_fire) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= dec_fire && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_fire && res_valid) begin
            r_out_word <= res_word;
        end
    end

    // replacement code register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl_code <= REPL_RESET;
        end else if (i_cfg_wr_en) begin
            r_repl_code <= i_cfg_wr_data;
        end
    end

`ifndef NO_ASSERTIONS
    // a waiting result is neither lost nor altered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_word)))
        else $error("result word changed while stalled");

    // a final byte always leaves the decoder idle
    a_eos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dec_fire && r_in_word.end_of_string) |=> (r_state.pending == PEND_NONE))
        else $error("sequence state not idle after end of string");

    // a final byte always yields a result word
    a_eos_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dec_fire && r_in_word.end_of_string) |=> (r_out_valid && r_out_word.string_done))
        else $error("end of string produced no result");

    // substituted words carry the replacement code in force at decode time
    a_repl_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dec_fire && res_valid && res_word.malformed)
            |=> (r_out_word.code_point == $past(r_repl_code)))
        else $error("malformed result without replacement code");
`endif

endmodule
